@@ sv/bbl_pkg.sv @@
`default_nettype none

package bbl_pkg;

    localparam int KEY_W   = 32;
    localparam int BYTES_W = 32;
    localparam int BUDGET_W = 37;
    localparam int CNT_W   = 5;

    localparam logic [BUDGET_W-1:0] USED_MAX = {BUDGET_W{1'b1}};
    localparam logic [CNT_W-1:0]    CNT_MAX  = {CNT_W{1'b1}};

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_GET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [KEY_W-1:0]   key;
        logic [BYTES_W-1:0] entry_bytes;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic [CNT_W-1:0]    evicted_count;
        logic [BUDGET_W-1:0] used_bytes;
        logic [CNT_W-1:0]    entries_used;
    } rsp_t;

    typedef logic [BUDGET_W-1:0] cfg_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [BYTES_W-1:0] bytes;
    } entry_t;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_CLEAR = 3'd1,
        OP_MATCH = 3'd2,
        OP_MOVE  = 3'd3,
        OP_DROP  = 3'd4,
        OP_SHIFT = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [KEY_W-1:0] key;
        logic             any_hit;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/bbl_chan_if.sv @@
`default_nettype none

interface bbl_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/bbl_cell.sv @@
`default_nettype none

module bbl_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bbl_pkg::cell_ctrl_t ctrl,
    input  wire bbl_pkg::entry_t    prev_entry,
    input  wire logic               prev_valid,
    input  wire logic               next_valid,
    input  wire logic               pre_in,
    output bbl_pkg::entry_t         entry,
    output logic                    valid,
    output logic                    pre_out,
    output logic                    hit_sel,
    output logic                    is_last
);

    bbl_pkg::entry_t entry_reg;
    bbl_pkg::entry_t entry_next;
    logic            valid_reg;
    logic            valid_next;
    logic            match_reg;
    logic            match_next;

    assign entry   = entry_reg;
    assign valid   = valid_reg;
    assign pre_out = pre_in | match_reg;
    assign hit_sel = match_reg & ~pre_in;
    assign is_last = valid_reg & ~next_valid;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        unique case (ctrl.op)
            bbl_pkg::OP_NONE:
            begin
            end
            bbl_pkg::OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            bbl_pkg::OP_MATCH:
            begin
                match_next = valid_reg && (entry_reg.key == ctrl.key);
            end
            bbl_pkg::OP_MOVE:
            begin
                if (ctrl.any_hit && !pre_in)
                begin
                    entry_next = prev_entry;
                end
            end
            bbl_pkg::OP_DROP:
            begin
                if (is_last)
                begin
                    valid_next = 1'b0;
                end
            end
            bbl_pkg::OP_SHIFT:
            begin
                entry_next = prev_entry;
                valid_next = prev_valid;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ sv/byte_budget_lru_directory_top.sv @@
// Size-aware LRU directory built as a row of ENTRIES cells, cell 0 most recent.
// One item at a time; req is ready only when the sequencer is idle, while a
// finished result may still wait in the output register. A get goes through
// accept, parallel key compare in all cells, move to front and result. A put
// goes through accept, a budget check and a drop of the last valid cell per
// entry it evicts, a final check, insert and result. A clear goes through
// accept, clear and result, an unused command through accept and result. After
// reset all entries are empty at once; there is no clearing pass. byte_budget
// may be written at any time the block is idle; it takes effect at the next put.
`default_nettype none

module byte_budget_lru_directory_top #(
    parameter int ENTRIES = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bbl_chan_if.sink    req,
    bbl_chan_if.source  rsp,
    bbl_chan_if.sink    cfg
);

    localparam int NW = $clog2(ENTRIES + 1);
    localparam int BW = bbl_pkg::BYTES_W + $clog2(ENTRIES);
    localparam int UW = (BW > bbl_pkg::BUDGET_W) ? BW : bbl_pkg::BUDGET_W;
    localparam int CW = UW + 1;
    localparam int NX = (NW > bbl_pkg::CNT_W) ? NW : bbl_pkg::CNT_W;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_PUT_CHK   = 8'b0000_0010,
        ST_PUT_DROP  = 8'b0000_0100,
        ST_PUT_INS   = 8'b0000_1000,
        ST_GET_MATCH = 8'b0001_0000,
        ST_GET_MOVE  = 8'b0010_0000,
        ST_CLEAR     = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic [1:0]                      cmd_reg, cmd_next;
    logic [bbl_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [bbl_pkg::BYTES_W-1:0]     size_reg, size_next;
    logic [BW-1:0]                   used_reg, used_next;
    logic [NW-1:0]                   n_reg, n_next;
    logic [bbl_pkg::CNT_W-1:0]       evict_reg, evict_next;
    logic                            hit_reg, hit_next;
    logic [bbl_pkg::BUDGET_W-1:0]    budget_reg, budget_next;
    logic                            out_valid_reg, out_valid_next;
    bbl_pkg::rsp_t                   out_data_reg, out_data_next;

    bbl_pkg::cell_ctrl_t             ctrl;
    bbl_pkg::entry_t                 ent [ENTRIES];
    bbl_pkg::entry_t                 front_entry;
    bbl_pkg::entry_t                 hit_entry;
    logic [bbl_pkg::BYTES_W-1:0]     last_bytes;
    logic [ENTRIES-1:0]              valid_vec;
    logic [ENTRIES-1:0]              pre_vec;
    logic [ENTRIES-1:0]              hit_vec;
    logic [ENTRIES-1:0]              last_vec;

    logic                            over_budget;
    logic                            must_drop;
    logic                            out_free;
    logic [UW-1:0]                   used_x;
    logic [NX-1:0]                   n_x;

    assign req.ready  = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;
    assign out_free   = ~out_valid_reg | rsp.ready;

    assign over_budget = (CW'(used_reg) + CW'(size_reg)) > CW'(budget_reg);
    assign must_drop   = ((budget_reg != '0) && (n_reg != '0) && over_budget)
                         || (n_reg == NW'(ENTRIES));

    assign used_x = UW'(used_reg);
    assign n_x    = NX'(n_reg);

    always_comb
    begin
        last_bytes = '0;
        hit_entry  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (last_vec[i])
            begin
                last_bytes = last_bytes | ent[i].bytes;
            end
            if (hit_vec[i])
            begin
                hit_entry = hit_entry | ent[i];
            end
        end
    end

    always_comb
    begin
        ctrl.key     = key_reg;
        ctrl.any_hit = pre_vec[ENTRIES-1];
        unique case (state_reg)
            ST_PUT_DROP:  ctrl.op = bbl_pkg::OP_DROP;
            ST_PUT_INS:   ctrl.op = bbl_pkg::OP_SHIFT;
            ST_GET_MATCH: ctrl.op = bbl_pkg::OP_MATCH;
            ST_GET_MOVE:  ctrl.op = bbl_pkg::OP_MOVE;
            ST_CLEAR:     ctrl.op = bbl_pkg::OP_CLEAR;
            default:      ctrl.op = bbl_pkg::OP_NONE;
        endcase
        if (state_reg == ST_GET_MOVE)
        begin
            front_entry = hit_entry;
        end
        else
        begin
            front_entry.key   = key_reg;
            front_entry.bytes = size_reg;
        end
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        bbl_pkg::entry_t prev_e;
        logic            prev_v;
        logic            next_v;
        logic            pre_i;

        if (g == 0)
        begin : g_head
            assign prev_e = front_entry;
            assign prev_v = 1'b1;
            assign pre_i  = 1'b0;
        end
        else
        begin : g_body
            assign prev_e = ent[g-1];
            assign prev_v = valid_vec[g-1];
            assign pre_i  = pre_vec[g-1];
        end

        if (g == ENTRIES - 1)
        begin : g_tail
            assign next_v = 1'b0;
        end
        else
        begin : g_mid
            assign next_v = valid_vec[g+1];
        end

        bbl_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_entry (prev_e),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .pre_in     (pre_i),
            .entry      (ent[g]),
            .valid      (valid_vec[g]),
            .pre_out    (pre_vec[g]),
            .hit_sel    (hit_vec[g]),
            .is_last    (last_vec[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        size_next      = size_reg;
        used_next      = used_reg;
        n_next         = n_reg;
        evict_next     = evict_reg;
        hit_next       = hit_reg;
        budget_next    = budget_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg.valid)
        begin
            budget_next = cfg.data;
        end
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.data.cmd;
                    key_next   = req.data.key;
                    size_next  = req.data.entry_bytes;
                    evict_next = '0;
                    hit_next   = 1'b0;
                    unique case (req.data.cmd)
                        bbl_pkg::CMD_PUT:   state_next = ST_PUT_CHK;
                        bbl_pkg::CMD_GET:   state_next = ST_GET_MATCH;
                        bbl_pkg::CMD_CLEAR: state_next = ST_CLEAR;
                        bbl_pkg::CMD_NOP:   state_next = ST_DONE;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_PUT_CHK:
            begin
                state_next = must_drop ? ST_PUT_DROP : ST_PUT_INS;
            end
            ST_PUT_DROP:
            begin
                used_next  = used_reg - BW'(last_bytes);
                n_next     = n_reg - NW'(1);
                evict_next = (evict_reg == bbl_pkg::CNT_MAX) ? evict_reg
                             : evict_reg + bbl_pkg::CNT_W'(1);
                state_next = ST_PUT_CHK;
            end
            ST_PUT_INS:
            begin
                used_next  = used_reg + BW'(size_reg);
                n_next     = n_reg + NW'(1);
                state_next = ST_DONE;
            end
            ST_GET_MATCH:
            begin
                state_next = ST_GET_MOVE;
            end
            ST_GET_MOVE:
            begin
                hit_next   = pre_vec[ENTRIES-1];
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                used_next  = '0;
                n_next     = '0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.hit            = hit_reg;
                    out_data_next.evicted_count  = evict_reg;
                    out_data_next.used_bytes     = (used_x > UW'(bbl_pkg::USED_MAX))
                                                   ? bbl_pkg::USED_MAX
                                                   : used_x[bbl_pkg::BUDGET_W-1:0];
                    out_data_next.entries_used   = (n_x > NX'(bbl_pkg::CNT_MAX))
                                                   ? bbl_pkg::CNT_MAX
                                                   : n_x[bbl_pkg::CNT_W-1:0];
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            n_reg         <= '0;
            evict_reg     <= '0;
            hit_reg       <= 1'b0;
            budget_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            n_reg         <= n_next;
            evict_reg     <= evict_next;
            hit_reg       <= hit_next;
            budget_reg    <= budget_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        size_reg     <= size_next;
        out_data_reg <= out_data_next;
    end

    logic cmd_is_put;
    assign cmd_is_put = (cmd_reg == bbl_pkg::CMD_PUT);

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(n_reg))
        else $error("entry count out of step with cell valid bits");

    a_no_gaps: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("valid cells are not packed from the front");

    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GET_MOVE) |-> $onehot0(hit_vec))
        else $error("more than one cell selected as first hit");

    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT_DROP) |-> ($onehot(last_vec) && (n_reg != '0)))
        else $error("eviction without a single last entry");

    a_put_inserts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT_INS) |-> (cmd_is_put && (n_reg != NW'(ENTRIES))))
        else $error("insert into a full directory");

endmodule

`default_nettype wire
